// ===== rtl/hdlcd_pkg.sv =====
// Package for the HDLC receive deframer: octet codes, result kinds and the
// byte-wide reflected CRC-16-CCITT update. No dependencies.
package hdlcd_pkg;

    localparam logic [7:0]  FLAG_OCTET = 8'h7E;
    localparam logic [7:0]  ESC_OCTET  = 8'h7D;
    localparam logic [7:0]  ESC_FLIP   = 8'h20;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [8:0]  LEN_CAP    = 9'd258;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    typedef logic [8:0] t_pos;

    // One octet through the reflected CRC, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] octet);
        logic [15:0] c;
        c = crc ^ {8'h00, octet};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/hdlcd_ifs.sv =====
// Handshake channels of the HDLC receive deframer: received octets in,
// result words out. Uses nothing from the package.
interface hdlcd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hdlcd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [7:0] payload_len;

    modport source (output valid, output out_kind, output out_byte, output payload_len,
                    input ready);
    modport sink   (input valid, input out_kind, input out_byte, input payload_len,
                    output ready);
endinterface

// ===== rtl/hdlc_async_deframer_crc16.sv =====
// Top level of the HDLC receive deframer with CRC-16-CCITT check.
// Depends on hdlcd_pkg and the channel interfaces in hdlcd_ifs.sv.
//
// Usage:
//   i_rx carries one received octet per word. o_res carries zero or one
//   result word per octet: a payload octet, a frame accepted verdict with
//   its payload length, or a frame rejected verdict. Flags, escapes and
//   the two trailing CRC octets produce no payload words.
//   i_cfg_we / i_cfg_wdata write max_len; write it only while idle.
// Timing:
//   An accepted octet is registered, processed against the frame state when
//   the processing stage advances, and its result word is registered and
//   valid from then on. One octet per cycle is sustained while o_res is ready;
//   the frame state is updated by one register stage per octet.
// Reset:
//   Synchronous, active low. Position and escape clear, the CRC returns
//   to 0xFFFF, max_len to 258, both channels go empty.
// Stall:
//   When o_res is held not ready with a result waiting, the processing
//   stage freezes and i_rx.ready drops once the input register is full.
module hdlc_async_deframer_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hdlcd_rx_if.sink    i_rx,
    hdlcd_res_if.source o_res,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    logic [1:0]         r_out_kind;
    logic [7:0]         r_out_byte;
    logic [7:0]         r_payload_len;
    hdlcd_pkg::t_pos    r_position, n_position;
    logic               r_escape, n_escape;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_recent0, n_recent0;
    logic [7:0]         r_recent1, n_recent1;
    logic [8:0]         r_max_len;

    logic               w_advance;
    logic               w_fire;
    logic               w_emit;
    logic [1:0]         w_kind;
    logic [7:0]         w_byte;
    logic [7:0]         w_len;

    // The processing stage moves whenever the result register is free or drains.
    assign w_advance = !r_out_valid || o_res.ready;
    assign w_fire    = r_in_valid && w_advance;
    assign i_rx.ready = !r_in_valid || w_advance;

    always_comb begin
        logic [7:0]      d;
        logic            is_data;
        logic            have;
        logic [8:0]      limit;
        hdlcd_pkg::t_pos pos1;

        n_position = r_position;
        n_escape   = r_escape;
        n_crc      = r_crc;
        n_recent0  = r_recent0;
        n_recent1  = r_recent1;
        w_emit     = 1'b0;
        w_kind     = hdlcd_pkg::KIND_PAYLOAD;
        w_byte     = 8'h00;
        w_len      = 8'h00;
        d          = r_in_byte;
        is_data    = 1'b0;
        have       = 1'b0;
        pos1       = r_position + 9'd1;

        if (r_max_len == 9'd0 || r_max_len > hdlcd_pkg::LEN_CAP) begin
            limit = hdlcd_pkg::LEN_CAP;
        end else begin
            limit = r_max_len;
        end

        if (w_fire) begin
            if (r_in_byte == hdlcd_pkg::FLAG_OCTET) begin
                if (r_position >= 9'd2) begin
                    w_emit = 1'b1;
                    // Trailing FCS is stored low octet first, so recent0 is the high half.
                    if (!r_escape && r_crc == {r_recent0, r_recent1}) begin
                        w_kind = hdlcd_pkg::KIND_ACCEPT;
                        w_len  = 8'(r_position - 9'd2);
                    end else begin
                        w_kind = hdlcd_pkg::KIND_REJECT;
                    end
                end
                n_position = '0;
                n_escape   = 1'b0;
                n_crc      = hdlcd_pkg::CRC_INIT;
            end else if (r_escape) begin
                n_escape = 1'b0;
                d        = r_in_byte ^ hdlcd_pkg::ESC_FLIP;
                is_data  = 1'b1;
            end else if (r_in_byte == hdlcd_pkg::ESC_OCTET) begin
                n_escape = 1'b1;
            end else begin
                is_data = 1'b1;
            end

            if (is_data) begin
                if (r_position >= 9'd2) begin
                    have  = 1'b1;
                    n_crc = hdlcd_pkg::crc_byte(r_crc, r_recent1);
                end
                n_recent1  = r_recent0;
                n_recent0  = d;
                n_position = pos1;
                if (pos1 == limit) begin
                    n_position = '0;
                    n_escape   = 1'b0;
                    n_crc      = hdlcd_pkg::CRC_INIT;
                    w_emit     = 1'b1;
                    w_kind     = hdlcd_pkg::KIND_REJECT;
                end else if (have) begin
                    w_emit = 1'b1;
                    w_kind = hdlcd_pkg::KIND_PAYLOAD;
                    w_byte = r_recent1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_position  <= '0;
            r_escape    <= 1'b0;
            r_crc       <= hdlcd_pkg::CRC_INIT;
            r_recent0   <= 8'h00;
            r_recent1   <= 8'h00;
            r_max_len   <= hdlcd_pkg::LEN_CAP;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (w_advance) begin
                r_out_valid <= w_emit;
            end
            r_position <= n_position;
            r_escape   <= n_escape;
            r_crc      <= n_crc;
            r_recent0  <= n_recent0;
            r_recent1  <= n_recent1;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_advance && w_emit) begin
            r_out_kind    <= w_kind;
            r_out_byte    <= w_byte;
            r_payload_len <= w_len;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_kind    = r_out_kind;
    assign o_res.out_byte    = r_out_byte;
    assign o_res.payload_len = r_payload_len;

    // A verdict word never carries a payload octet.
    a_byte_zero_on_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind != hdlcd_pkg::KIND_PAYLOAD |-> r_out_byte == 8'h00)
        else $error("verdict word carries a nonzero byte");

    // Only an accepted frame reports a length.
    a_len_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind != hdlcd_pkg::KIND_ACCEPT |-> r_payload_len == 8'h00)
        else $error("length reported outside an accepted frame");

    // A stalled result word holds still until it is taken.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready
        |=> r_out_valid && $stable(r_out_kind) && $stable(r_out_byte)
            && $stable(r_payload_len))
        else $error("result word changed while stalled");

    // A processed flag restarts reception.
    a_flag_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in_byte == hdlcd_pkg::FLAG_OCTET
        |=> r_position == '0 && !r_escape && r_crc == hdlcd_pkg::CRC_INIT)
        else $error("flag did not restart reception");

endmodule
